/* rtl/bsc_pkg.sv */
// Shared types and constants for the barometric compensation core.
// No dependencies; bsc_ifs, bsc_div and the core import this package.
package bsc_pkg;

   localparam int AdcW     = 20;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;
   localparam int DivSteps = 64;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_T1  = 3'd0,
      CSR_T23 = 3'd1,
      CSR_P12 = 3'd2,
      CSR_P34 = 3'd3,
      CSR_P56 = 3'd4,
      CSR_P78 = 3'd5,
      CSR_P9  = 3'd6
   } csr_idx_type;

   localparam logic signed [25:0] FineOffset = 26'sd128000;
   localparam logic signed [63:0] HalfScale  = 64'sh0000_8000_0000_0000;
   localparam logic signed [63:0] PresScale  = 64'sd3125;
   localparam logic        [20:0] PresFull   = 21'd1048576;

   // sideband that rides along the divider and the tail stages
   typedef struct packed {
      logic signed [15:0] temp;
      logic               zero;
      logic               neg;
   } div_side_type;

endpackage

/* rtl/bsc_ifs.sv */
// Channel interfaces of the compensation core: readings, results, register writes.
// Depends on bsc_pkg.
interface bsc_req_if;
   import bsc_pkg::*;
   logic            valid;
   logic            ready;
   logic [AdcW-1:0] adc_pressure;
   logic [AdcW-1:0] adc_temperature;
   modport source (output valid, adc_pressure, adc_temperature, input ready);
   modport sink (input valid, adc_pressure, adc_temperature, output ready);
endinterface

interface bsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] temperature_centi_c;
   logic        [31:0] pressure_q24_8;
   logic               divisor_zero;
   modport source (output valid, temperature_centi_c, pressure_q24_8, divisor_zero,
                   input ready);
   modport sink (input valid, temperature_centi_c, pressure_q24_8, divisor_zero,
                 output ready);
endinterface

interface bsc_csr_if;
   import bsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bsc_div.sv */
// Pipelined unsigned 64 by 32 bit restoring divider, one quotient bit per stage.
// Depends on bsc_pkg for the step count and the sideband type.
module bsc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  logic [63:0]           in_num,
   input  logic [31:0]           in_dvs,
   input  bsc_pkg::div_side_type in_side,
   output logic                  out_vld,
   output logic [63:0]           out_quo,
   output bsc_pkg::div_side_type out_side
);
   import bsc_pkg::*;

   logic [31:0]  rem_ff  [1:DivSteps];
   logic [63:0]  nq_ff   [1:DivSteps];
   logic [31:0]  dvs_ff  [1:DivSteps];
   div_side_type side_ff [1:DivSteps];
   logic         vld_ff  [1:DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [31:0]  rem_src;
      logic [63:0]  nq_src;
      logic [31:0]  dvs_src;
      div_side_type side_src;
      logic         vld_src;
      logic [31:0]  rsh;
      logic [32:0]  trial;
      logic [31:0]  rem_in;
      logic [63:0]  nq_in;

      if (k == 0) begin : g_head
         assign rem_src  = '0;
         assign nq_src   = in_num;
         assign dvs_src  = in_dvs;
         assign side_src = in_side;
         assign vld_src  = in_vld;
      end else begin : g_body
         assign rem_src  = rem_ff[k];
         assign nq_src   = nq_ff[k];
         assign dvs_src  = dvs_ff[k];
         assign side_src = side_ff[k];
         assign vld_src  = vld_ff[k];
      end

      // shift in the next numerator bit, subtract when it fits
      assign rsh    = {rem_src[30:0], nq_src[63]};
      assign trial  = {1'b0, rsh} - {1'b0, dvs_src};
      assign rem_in = trial[32] ? rsh : trial[31:0];
      assign nq_in  = {nq_src[62:0], ~trial[32]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= rem_in;
            nq_ff[k+1]   <= nq_in;
            dvs_ff[k+1]  <= dvs_src;
            side_ff[k+1] <= side_src;
         end
      end
   end

   assign out_vld  = vld_ff[DivSteps];
   assign out_quo  = nq_ff[DivSteps];
   assign out_side = side_ff[DivSteps];

endmodule

/* rtl/barometric_sensor_compensation_core.sv */
// Path: a reading passes 11 polynomial stages, 64 divider stages, 5 tail stages and the
// output register before its result shows on rsp. Throughput: one reading per cycle;
// the whole pipeline advances together and holds while a result waits.
// Reset (synchronous) clears every valid bit and all coefficient registers to zero.
// Depends on bsc_pkg, bsc_ifs and bsc_div.
module barometric_sensor_compensation_core (
   input  logic      clock,
   input  logic      reset,
   bsc_req_if.sink   req_if,
   bsc_rsp_if.source rsp_if,
   bsc_csr_if.sink   csr_if
);
   import bsc_pkg::*;

   // coefficient registers
   logic [15:0] t1_ff, p9_ff;
   logic [31:0] t23_ff, p12_ff, p34_ff, p56_ff, p78_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff  <= '0;
         t23_ff <= '0;
         p12_ff <= '0;
         p34_ff <= '0;
         p56_ff <= '0;
         p78_ff <= '0;
         p9_ff  <= '0;
      end else if (csr_if.valid) begin
         case (csr_idx_type'(csr_if.index))
            CSR_T1:  t1_ff  <= csr_if.data[15:0];
            CSR_T23: t23_ff <= csr_if.data;
            CSR_P12: p12_ff <= csr_if.data;
            CSR_P34: p34_ff <= csr_if.data;
            CSR_P56: p56_ff <= csr_if.data;
            CSR_P78: p78_ff <= csr_if.data;
            CSR_P9:  p9_ff  <= csr_if.data[15:0];
            default: ;
         endcase
      end
   end

   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [16:0] p1x;
   assign t2  = t23_ff[15:0];
   assign t3  = t23_ff[31:16];
   assign p1x = {1'b0, p12_ff[15:0]};
   assign p2  = p12_ff[31:16];
   assign p3  = p34_ff[15:0];
   assign p4  = p34_ff[31:16];
   assign p5  = p56_ff[15:0];
   assign p6  = p56_ff[31:16];
   assign p7  = p78_ff[15:0];
   assign p8  = p78_ff[31:16];
   assign p9  = p9_ff;

   // global advance: hold everything while the output waits
   logic o_vld_ff;
   logic adv;
   assign adv          = !o_vld_ff || rsp_if.ready;
   assign req_if.ready = adv;

   logic [11:1] pv_ff;
   logic [5:1]  qv_ff;
   logic        dv_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff    <= '0;
         qv_ff    <= '0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         pv_ff    <= {pv_ff[10:1], req_if.valid};
         qv_ff    <= {qv_ff[4:1], dv_vld};
         o_vld_ff <= qv_ff[5];
      end
   end

   // front stages: temperature polynomial
   logic signed [17:0] d1_in, d1_ff;
   logic signed [16:0] d2_in, d2_ff;
   logic [AdcW-1:0]    ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff, ap7_ff, ap8_ff;
   logic signed [33:0] m1_in, m1_ff, sq_in, sq_ff;
   logic signed [22:0] v1_in, v1_ff;
   logic signed [21:0] sq_sh;
   logic signed [37:0] m2_in, m2_ff;
   logic signed [23:0] m2_sh;
   logic signed [24:0] fine_in, fine_ff;
   logic signed [27:0] tround;
   logic signed [19:0] tshift;
   logic signed [15:0] temp_in, tp5_ff, tp6_ff, tp7_ff, tp8_ff, tp9_ff, tp10_ff;
   logic signed [25:0] a_in, a_ff;

   assign d1_in   = $signed({1'b0, req_if.adc_temperature[19:3]}) - $signed({1'b0, t1_ff, 1'b0});
   assign d2_in   = $signed({1'b0, req_if.adc_temperature[19:4]}) - $signed({1'b0, t1_ff});
   assign m1_in   = d1_ff * t2;
   assign sq_in   = d2_ff * d2_ff;
   assign v1_in   = m1_ff[33:11];
   assign sq_sh   = sq_ff[33:12];
   assign m2_in   = sq_sh * t3;
   assign m2_sh   = m2_ff[37:14];
   assign fine_in = v1_ff + m2_sh;
   assign tround  = fine_ff * 28'sd5 + 28'sd128;
   assign tshift  = tround[27:8];
   assign a_in    = fine_ff - FineOffset;

   always_comb begin
      if (tshift > 20'sd32767) begin
         temp_in = 16'sh7FFF;
      end else if (tshift < -20'sd32768) begin
         temp_in = 16'sh8000;
      end else begin
         temp_in = tshift[15:0];
      end
   end

   // pressure polynomial
   logic signed [51:0] aa_in, aa_ff;
   logic signed [41:0] ap5m_in, ap5m_ff, ap5m2_ff, ap2m_in, ap2m_ff, ap2m2_ff;
   logic signed [63:0] aap6_in, aap6_ff, aap3_in, aap3_ff;
   logic signed [63:0] ap5x, ap2x, p4x;
   logic signed [63:0] b_in, b_ff, amid_in, amid_ff;
   logic signed [63:0] prod_in, prod_ff, n0_in, n0_ff;
   logic        [20:0] pp;
   logic signed [30:0] dv_in, dv_ff;
   logic signed [63:0] num_in, num_ff;
   logic signed [31:0] dvx;
   logic        [63:0] unum_in, unum_ff;
   logic        [31:0] udv_in, udv_ff;
   div_side_type       side_in, side_ff;

   assign aa_in   = a_ff * a_ff;
   assign ap5m_in = a_ff * p5;
   assign ap2m_in = a_ff * p2;
   assign aap6_in = aa_ff * p6;
   assign aap3_in = aa_ff * p3;
   assign ap5x    = ap5m2_ff;
   assign ap2x    = ap2m2_ff;
   assign p4x     = p4;
   assign b_in    = aap6_ff + (ap5x <<< 17) + (p4x <<< 35);
   assign amid_in = (aap3_ff >>> 8) + (ap2x <<< 12);
   assign prod_in = (HalfScale + amid_ff) * p1x;
   assign pp      = PresFull - {1'b0, ap8_ff};
   assign n0_in   = $signed({12'd0, pp, 31'd0}) - b_ff;
   assign dv_in   = prod_ff[63:33];
   assign num_in  = n0_ff * PresScale;
   assign dvx     = dv_ff;
   assign unum_in = num_ff[63] ? -num_ff : num_ff;
   assign udv_in  = dv_ff[30] ? -dvx : dvx;

   always_comb begin
      side_in.temp = tp10_ff;
      side_in.zero = (dv_ff == '0);
      side_in.neg  = num_ff[63] ^ dv_ff[30];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         ap1_ff   <= req_if.adc_pressure;
         m1_ff    <= m1_in;
         sq_ff    <= sq_in;
         ap2_ff   <= ap1_ff;
         v1_ff    <= v1_in;
         m2_ff    <= m2_in;
         ap3_ff   <= ap2_ff;
         fine_ff  <= fine_in;
         ap4_ff   <= ap3_ff;
         tp5_ff   <= temp_in;
         a_ff     <= a_in;
         ap5_ff   <= ap4_ff;
         aa_ff    <= aa_in;
         ap5m_ff  <= ap5m_in;
         ap2m_ff  <= ap2m_in;
         tp6_ff   <= tp5_ff;
         ap6_ff   <= ap5_ff;
         aap6_ff  <= aap6_in;
         aap3_ff  <= aap3_in;
         ap5m2_ff <= ap5m_ff;
         ap2m2_ff <= ap2m_ff;
         tp7_ff   <= tp6_ff;
         ap7_ff   <= ap6_ff;
         b_ff     <= b_in;
         amid_ff  <= amid_in;
         tp8_ff   <= tp7_ff;
         ap8_ff   <= ap7_ff;
         prod_ff  <= prod_in;
         n0_ff    <= n0_in;
         tp9_ff   <= tp8_ff;
         dv_ff    <= dv_in;
         num_ff   <= num_in;
         tp10_ff  <= tp9_ff;
         unum_ff  <= unum_in;
         udv_ff   <= udv_in;
         side_ff  <= side_in;
      end
   end

   // magnitude division
   logic [63:0]  quo;
   div_side_type dside;

   bsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (pv_ff[11]),
      .in_num   (unum_ff),
      .in_dvs   (udv_ff),
      .in_side  (side_ff),
      .out_vld  (dv_vld),
      .out_quo  (quo),
      .out_side (dside)
   );

   // tail: second-order pressure correction
   logic signed [63:0] q1_in, q1_ff, q2_ff, q3_ff, q4_ff;
   logic signed [63:0] x;
   logic        [31:0] xl, xh;
   logic        [63:0] ll_in, ll_ff;
   logic        [31:0] lh_in, lh_ff;
   logic signed [63:0] p8q_in, p8q_ff, xx_in, xx_ff, v2_in, v2_ff, v2b_ff;
   logic signed [63:0] v1m_in, v1m_ff, sum_in, sum_ff, p7x, pres_full;
   div_side_type       s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic signed [15:0] o_temp_ff;
   logic        [31:0] o_pres_ff;
   logic               o_zero_ff;

   assign q1_in     = dside.neg ? -$signed(quo) : $signed(quo);
   assign x         = q1_ff >>> 13;
   assign xl        = x[31:0];
   assign xh        = x[63:32];
   assign ll_in     = xl * xl;
   assign lh_in     = xl * xh;
   assign p8q_in    = q1_ff * p8;
   assign xx_in     = $signed(ll_ff + {lh_ff[30:0], 33'd0});
   assign v2_in     = p8q_ff >>> 19;
   assign v1m_in    = xx_ff * p9;
   assign sum_in    = q4_ff + (v1m_ff >>> 25) + v2b_ff;
   assign p7x       = p7;
   assign pres_full = (sum_ff >>> 8) + (p7x <<< 4);

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff     <= q1_in;
         s1_ff     <= dside;
         q2_ff     <= q1_ff;
         ll_ff     <= ll_in;
         lh_ff     <= lh_in;
         p8q_ff    <= p8q_in;
         s2_ff     <= s1_ff;
         q3_ff     <= q2_ff;
         xx_ff     <= xx_in;
         v2_ff     <= v2_in;
         s3_ff     <= s2_ff;
         q4_ff     <= q3_ff;
         v1m_ff    <= v1m_in;
         v2b_ff    <= v2_ff;
         s4_ff     <= s3_ff;
         sum_ff    <= sum_in;
         s5_ff     <= s4_ff;
         o_temp_ff <= s5_ff.temp;
         o_zero_ff <= s5_ff.zero;
         o_pres_ff <= s5_ff.zero ? 32'd0 : pres_full[31:0];
      end
   end

   assign rsp_if.valid               = o_vld_ff;
   assign rsp_if.temperature_centi_c = o_temp_ff;
   assign rsp_if.pressure_q24_8      = o_pres_ff;
   assign rsp_if.divisor_zero        = o_zero_ff;

endmodule

/* rtl/bsc_chk.sv */
// Port-level checks for the compensation core, attached by bind.
// Depends on barometric_sensor_compensation_core.
module bsc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pressure,
   input logic        rsp_zero,
   input logic        csr_ready
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pressure))
      else $error("stalled result changed");

   // a stalled output must block new readings
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("reading taken while output stalled");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero |-> rsp_pressure == 32'd0)
      else $error("zero divisor with nonzero pressure");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind barometric_sensor_compensation_core bsc_chk u_bsc_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_pressure (rsp_if.pressure_q24_8),
   .rsp_zero     (rsp_if.divisor_zero),
   .csr_ready    (csr_if.ready)
);
